### rtl/wrol_pkg.sv
// ----------------------------------------------------------------------------
// wrol_pkg
// Shared constants, types and saturation helpers for the record ring with
// offset lookup.
// ----------------------------------------------------------------------------
package wrol_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SIZE_BITS  = 16;

    localparam int IDX_BITS   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_BITS   = $clog2(SLOT_COUNT + 1);
    localparam int ACC_BITS   = SIZE_BITS + CNT_BITS;

    localparam int HANDLE_W   = 32;
    localparam int IN_SIZE_W  = 16;
    localparam int OFFSET_W   = 20;
    localparam int REC_W      = 4;
    localparam int HALF_W     = 16;
    localparam int SUM_W      = 20;

    localparam int SAT_W      = (ACC_BITS > SUM_W) ? ACC_BITS + 1 : SUM_W + 1;
    localparam int HB_W       = (SIZE_BITS > HALF_W) ? SIZE_BITS : HALF_W;
    localparam int RC_W       = (CNT_BITS > REC_W) ? CNT_BITS : REC_W;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_FIND     = 2'd1,
        OP_TOTAL    = 2'd2,
        OP_POSITION = 2'd3
    } op_t;

    typedef struct packed {
        op_t  op;
        logic last;
    } step_ctl_t;

    function automatic logic [SUM_W-1:0] sat_sum(input logic [ACC_BITS-1:0] v);
        logic [SAT_W-1:0] w;
        w = SAT_W'(v);
        if (w > SAT_W'({SUM_W{1'b1}})) begin
            return {SUM_W{1'b1}};
        end
        return w[SUM_W-1:0];
    endfunction

    function automatic logic [HALF_W-1:0] sat_half(input logic [SIZE_BITS-1:0] v);
        logic [HB_W-1:0] w;
        w = HB_W'(v);
        if (w > HB_W'({HALF_W{1'b1}})) begin
            return {HALF_W{1'b1}};
        end
        return w[HALF_W-1:0];
    endfunction

endpackage

### rtl/wrol_slot_mem.sv
// ----------------------------------------------------------------------------
// wrol_slot_mem
// Record slot storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wrol_slot_mem (
    input  logic                               aclk,
    input  logic                               wr_en,
    input  logic [wrol_pkg::IDX_BITS-1:0]      wr_addr,
    input  logic [wrol_pkg::HANDLE_W-1:0]      wr_handle,
    input  logic [wrol_pkg::SIZE_BITS-1:0]     wr_size,
    input  logic [wrol_pkg::IDX_BITS-1:0]      rd_addr,
    output logic [wrol_pkg::HANDLE_W-1:0]      rd_handle,
    output logic [wrol_pkg::SIZE_BITS-1:0]     rd_size
);

    logic [wrol_pkg::HANDLE_W-1:0]  handle_mem [wrol_pkg::SLOT_COUNT];
    logic [wrol_pkg::SIZE_BITS-1:0] size_mem   [wrol_pkg::SLOT_COUNT];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            handle_mem[wr_addr] <= wr_handle;
            size_mem[wr_addr]   <= wr_size;
        end
        rd_handle <= handle_mem[rd_addr];
        rd_size   <= size_mem[rd_addr];
    end

endmodule

### rtl/wrol_step_unit.sv
// ----------------------------------------------------------------------------
// wrol_step_unit
// Shared add and compare step applied to one stored record per cycle.
// ----------------------------------------------------------------------------
module wrol_step_unit (
    input  wrol_pkg::step_ctl_t                ctl,
    input  logic [wrol_pkg::ACC_BITS-1:0]      acc,
    input  logic [wrol_pkg::SIZE_BITS-1:0]     size,
    input  logic [wrol_pkg::OFFSET_W-1:0]      target,
    input  logic [wrol_pkg::IN_SIZE_W-1:0]     byte_val,
    output logic [wrol_pkg::ACC_BITS-1:0]      sum,
    output logic [wrol_pkg::SIZE_BITS-1:0]     diff,
    output logic                               hit
);

    logic [wrol_pkg::SIZE_BITS-1:0] addend;
    logic [wrol_pkg::SAT_W-1:0]     wide_diff;

    always_comb begin
        if (ctl.op == wrol_pkg::OP_POSITION && ctl.last) begin
            addend = wrol_pkg::SIZE_BITS'(byte_val);
        end else begin
            addend = size;
        end
        sum       = acc + wrol_pkg::ACC_BITS'(addend);
        wide_diff = wrol_pkg::SAT_W'(target) - wrol_pkg::SAT_W'(acc);
        diff      = wide_diff[wrol_pkg::SIZE_BITS-1:0];
        unique case (ctl.op)
            wrol_pkg::OP_FIND: begin
                hit = wrol_pkg::SAT_W'(target) < wrol_pkg::SAT_W'(sum);
            end
            wrol_pkg::OP_POSITION: begin
                hit = wrol_pkg::HB_W'(byte_val) < wrol_pkg::HB_W'(size);
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

endmodule

### rtl/write_ring_offset_lookup_top.sv
// ----------------------------------------------------------------------------
// write_ring_offset_lookup_top
// Overwriting ring of record slots with find, total and position lookups.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  s_      | s_valid s_ready s_operation ... s_byte_in_record | in
//  m_      | m_valid m_ready m_ok ... m_sum_bytes     | out
//
//  an add, or a request with no record to walk, goes from ST_IDLE to ST_DONE;
//  find, total and position first walk N records in ST_WALK, N the stored
//  count, or record_number + 1, or fewer when a find hits early
//  the walk reads one slot per cycle through the single memory read port and
//  the shared adder and comparator
//  reset is synchronous active low and empties the ring; slot contents are
//  not cleared
//  a finished result waits in the output register; s_ready is high only while
//  no request is being walked or waiting to be moved to the output register
// ----------------------------------------------------------------------------
module write_ring_offset_lookup_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_operation,
    input  logic [wrol_pkg::HANDLE_W-1:0]      s_record_handle,
    input  logic [wrol_pkg::IN_SIZE_W-1:0]     s_record_size,
    input  logic [wrol_pkg::OFFSET_W-1:0]      s_byte_offset,
    input  logic [wrol_pkg::REC_W-1:0]         s_record_number,
    input  logic [wrol_pkg::IN_SIZE_W-1:0]     s_byte_in_record,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_ok,
    output logic [wrol_pkg::HANDLE_W-1:0]      m_found_handle,
    output logic [wrol_pkg::HALF_W-1:0]        m_found_size,
    output logic [wrol_pkg::HALF_W-1:0]        m_offset_in_found,
    output logic [wrol_pkg::SUM_W-1:0]         m_sum_bytes
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t                              state_reg;
    wrol_pkg::op_t                       op_reg;
    logic [wrol_pkg::IDX_BITS-1:0]       write_idx_reg;
    logic [wrol_pkg::IDX_BITS-1:0]       oldest_idx_reg;
    logic                                ring_full_reg;
    logic [wrol_pkg::IDX_BITS-1:0]       idx_reg;
    logic [wrol_pkg::CNT_BITS-1:0]       issue_cnt_reg;
    logic [wrol_pkg::CNT_BITS-1:0]       proc_cnt_reg;
    logic [wrol_pkg::CNT_BITS-1:0]       lim_reg;
    logic                                rd_vld_reg;
    logic [wrol_pkg::ACC_BITS-1:0]       acc_reg;
    logic [wrol_pkg::OFFSET_W-1:0]       target_reg;
    logic [wrol_pkg::IN_SIZE_W-1:0]      byte_reg;

    logic                                res_ok_reg;
    logic [wrol_pkg::HANDLE_W-1:0]       res_handle_reg;
    logic [wrol_pkg::HALF_W-1:0]         res_size_reg;
    logic [wrol_pkg::HALF_W-1:0]         res_off_reg;
    logic [wrol_pkg::SUM_W-1:0]          res_sum_reg;

    logic                                m_valid_reg;
    logic                                m_ok_reg;
    logic [wrol_pkg::HANDLE_W-1:0]       m_handle_reg;
    logic [wrol_pkg::HALF_W-1:0]         m_size_reg;
    logic [wrol_pkg::HALF_W-1:0]         m_off_reg;
    logic [wrol_pkg::SUM_W-1:0]          m_sum_reg;

    wrol_pkg::op_t                       in_op;
    logic                                in_xfer;
    logic [wrol_pkg::CNT_BITS-1:0]       stored_cnt;
    logic [wrol_pkg::IDX_BITS-1:0]       first_idx;
    logic [wrol_pkg::CNT_BITS-1:0]       walk_len;
    logic [wrol_pkg::IDX_BITS-1:0]       write_idx_inc;
    logic [wrol_pkg::IDX_BITS-1:0]       oldest_idx_inc;
    logic [wrol_pkg::IDX_BITS-1:0]       oldest_idx_new;
    logic [wrol_pkg::IDX_BITS-1:0]       idx_inc;
    logic                                issue;
    logic                                last;
    logic [wrol_pkg::HANDLE_W-1:0]       rd_handle;
    logic [wrol_pkg::SIZE_BITS-1:0]      rd_size;
    wrol_pkg::step_ctl_t                 step_ctl;
    logic [wrol_pkg::ACC_BITS-1:0]       step_sum;
    logic [wrol_pkg::SIZE_BITS-1:0]      step_diff;
    logic                                step_hit;

    function automatic logic [wrol_pkg::IDX_BITS-1:0] next_slot(
        input logic [wrol_pkg::IDX_BITS-1:0] i
    );
        if (i == wrol_pkg::IDX_BITS'(wrol_pkg::SLOT_COUNT - 1)) begin
            return '0;
        end
        return i + 1'b1;
    endfunction

    assign s_ready           = (state_reg == ST_IDLE);
    assign in_xfer           = s_valid && s_ready;
    assign in_op             = wrol_pkg::op_t'(s_operation);

    assign m_valid           = m_valid_reg;
    assign m_ok              = m_ok_reg;
    assign m_found_handle    = m_handle_reg;
    assign m_found_size      = m_size_reg;
    assign m_offset_in_found = m_off_reg;
    assign m_sum_bytes       = m_sum_reg;

    assign write_idx_inc  = next_slot(write_idx_reg);
    assign oldest_idx_inc = next_slot(oldest_idx_reg);
    assign oldest_idx_new = ring_full_reg ? oldest_idx_inc : oldest_idx_reg;
    assign idx_inc        = next_slot(idx_reg);

    always_comb begin
        stored_cnt = ring_full_reg ? wrol_pkg::CNT_BITS'(wrol_pkg::SLOT_COUNT)
                                   : wrol_pkg::CNT_BITS'(write_idx_reg);
        first_idx  = ring_full_reg ? oldest_idx_reg : '0;
        if (in_op == wrol_pkg::OP_POSITION) begin
            if (wrol_pkg::RC_W'(s_record_number) < wrol_pkg::RC_W'(stored_cnt)) begin
                walk_len = wrol_pkg::CNT_BITS'(s_record_number) + 1'b1;
            end else begin
                walk_len = '0;
            end
        end else begin
            walk_len = stored_cnt;
        end
    end

    assign issue         = (state_reg == ST_WALK) && (issue_cnt_reg != lim_reg);
    assign last          = (proc_cnt_reg + 1'b1) == lim_reg;
    assign step_ctl.op   = op_reg;
    assign step_ctl.last = last;

    wrol_slot_mem u_slot_mem (
        .aclk      (aclk),
        .wr_en     (in_xfer && in_op == wrol_pkg::OP_ADD),
        .wr_addr   (write_idx_reg),
        .wr_handle (s_record_handle),
        .wr_size   (wrol_pkg::SIZE_BITS'(s_record_size)),
        .rd_addr   (idx_reg),
        .rd_handle (rd_handle),
        .rd_size   (rd_size)
    );

    wrol_step_unit u_step_unit (
        .ctl      (step_ctl),
        .acc      (acc_reg),
        .size     (rd_size),
        .target   (target_reg),
        .byte_val (byte_reg),
        .sum      (step_sum),
        .diff     (step_diff),
        .hit      (step_hit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            write_idx_reg  <= '0;
            oldest_idx_reg <= '0;
            ring_full_reg  <= 1'b0;
            rd_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg         <= in_op;
                        target_reg     <= s_byte_offset;
                        byte_reg       <= s_byte_in_record;
                        idx_reg        <= first_idx;
                        issue_cnt_reg  <= '0;
                        proc_cnt_reg   <= '0;
                        lim_reg        <= walk_len;
                        acc_reg        <= '0;
                        rd_vld_reg     <= 1'b0;
                        res_ok_reg     <= 1'b0;
                        res_handle_reg <= '0;
                        res_size_reg   <= '0;
                        res_off_reg    <= '0;
                        res_sum_reg    <= '0;
                        if (in_op == wrol_pkg::OP_ADD) begin
                            write_idx_reg  <= write_idx_inc;
                            oldest_idx_reg <= oldest_idx_new;
                            if (write_idx_inc == oldest_idx_new) begin
                                ring_full_reg <= 1'b1;
                            end
                            state_reg <= ST_DONE;
                        end else if (walk_len == '0) begin
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    rd_vld_reg <= issue;
                    if (issue) begin
                        idx_reg       <= idx_inc;
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end
                    if (rd_vld_reg) begin
                        proc_cnt_reg <= proc_cnt_reg + 1'b1;
                        acc_reg      <= step_sum;
                        unique case (op_reg)
                            wrol_pkg::OP_FIND: begin
                                if (step_hit) begin
                                    res_ok_reg     <= 1'b1;
                                    res_handle_reg <= rd_handle;
                                    res_size_reg   <= wrol_pkg::sat_half(rd_size);
                                    res_off_reg    <= wrol_pkg::sat_half(step_diff);
                                    state_reg      <= ST_DONE;
                                end else if (last) begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            wrol_pkg::OP_TOTAL: begin
                                if (last) begin
                                    res_sum_reg <= wrol_pkg::sat_sum(step_sum);
                                    state_reg   <= ST_DONE;
                                end
                            end
                            wrol_pkg::OP_POSITION: begin
                                if (last) begin
                                    res_ok_reg <= step_hit;
                                    if (step_hit) begin
                                        res_sum_reg <= wrol_pkg::sat_sum(step_sum);
                                    end
                                    state_reg <= ST_DONE;
                                end
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_DONE: begin
                    rd_vld_reg <= 1'b0;
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_ok_reg     <= res_ok_reg;
                        m_handle_reg <= res_handle_reg;
                        m_size_reg   <= res_size_reg;
                        m_off_reg    <= res_off_reg;
                        m_sum_reg    <= res_sum_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the record ring with offset lookup. A driver feeds
// adds, finds, totals and position requests from a queue; a local copy of the
// ring predicts every result, and the monitor compares each returned result
// field by field. Runs directed corner cases, then random traffic under
// several sender and receiver throttling patterns and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import wrol_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 40;
    localparam int PHASE_ITEMS    = 118;

    typedef struct {
        op_t                  op;
        logic [HANDLE_W-1:0]  handle;
        logic [IN_SIZE_W-1:0] size;
        logic [OFFSET_W-1:0]  offset;
        logic [REC_W-1:0]     rec_num;
        logic [IN_SIZE_W-1:0] byte_in;
    } lookup_req_t;

    typedef struct {
        logic                ok;
        logic [HANDLE_W-1:0] handle;
        logic [HALF_W-1:0]   size;
        logic [HALF_W-1:0]   offs;
        logic [SUM_W-1:0]    sum;
    } lookup_res_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_operation = OP_ADD;
    logic [HANDLE_W-1:0]  s_record_handle = '0;
    logic [IN_SIZE_W-1:0] s_record_size = '0;
    logic [OFFSET_W-1:0]  s_byte_offset = '0;
    logic [REC_W-1:0]     s_record_number = '0;
    logic [IN_SIZE_W-1:0] s_byte_in_record = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_ok;
    logic [HANDLE_W-1:0]  m_found_handle;
    logic [HALF_W-1:0]    m_found_size;
    logic [HALF_W-1:0]    m_offset_in_found;
    logic [SUM_W-1:0]     m_sum_bytes;

    write_ring_offset_lookup_top uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_record_handle   (s_record_handle),
        .s_record_size     (s_record_size),
        .s_byte_offset     (s_byte_offset),
        .s_record_number   (s_record_number),
        .s_byte_in_record  (s_byte_in_record),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_ok              (m_ok),
        .m_found_handle    (m_found_handle),
        .m_found_size      (m_found_size),
        .m_offset_in_found (m_offset_in_found),
        .m_sum_bytes       (m_sum_bytes)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    lookup_req_t pending_reqs[$];
    lookup_res_t expected_results[$];
    int unsigned gen_sizes[$];

    logic [HANDLE_W-1:0]  ring_handle [SLOT_COUNT];
    logic [SIZE_BITS-1:0] ring_size [SLOT_COUNT];
    int                   wr_slot = 0;
    int                   old_slot = 0;
    bit                   ring_wrapped = 1'b0;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_request = 1'b0;
    int          hold_left = 0;
    bit          s_accepted = 1'b0;
    int          idle_cycles = 0;
    int          n_errors = 0;
    bit          timed_out = 1'b0;
    lookup_req_t cur_req;
    lookup_req_t seen_req;
    lookup_res_t want;

    function automatic longint unsigned clip(longint unsigned v, longint unsigned top);
        return (v > top) ? top : v;
    endfunction

    function automatic lookup_res_t apply_request(lookup_req_t r);
        lookup_res_t       res;
        int                n;
        int                slot;
        longint unsigned   pos;
        res = '{default: '0};
        n = ring_wrapped ? SLOT_COUNT : wr_slot;
        slot = ring_wrapped ? old_slot : 0;
        pos = 0;
        case (r.op)
            OP_ADD: begin
                ring_handle[wr_slot] = r.handle;
                ring_size[wr_slot] = SIZE_BITS'(r.size);
                wr_slot = (wr_slot + 1) % SLOT_COUNT;
                if (ring_wrapped) begin
                    old_slot = (old_slot + 1) % SLOT_COUNT;
                end
                if (wr_slot == old_slot) begin
                    ring_wrapped = 1'b1;
                end
            end
            OP_FIND: begin
                for (int i = 0; i < n; i++) begin
                    if (r.offset < pos + ring_size[slot]) begin
                        res.ok = 1'b1;
                        res.handle = ring_handle[slot];
                        res.size = HALF_W'(clip(ring_size[slot], 2**HALF_W - 1));
                        res.offs = HALF_W'(clip(r.offset - pos, 2**HALF_W - 1));
                        break;
                    end
                    pos += ring_size[slot];
                    slot = (slot + 1) % SLOT_COUNT;
                end
            end
            OP_TOTAL: begin
                for (int i = 0; i < n; i++) begin
                    pos += ring_size[slot];
                    slot = (slot + 1) % SLOT_COUNT;
                end
                res.sum = SUM_W'(clip(pos, 2**SUM_W - 1));
            end
            default: begin
                if (r.rec_num < n) begin
                    for (int i = 0; i < r.rec_num; i++) begin
                        pos += ring_size[slot];
                        slot = (slot + 1) % SLOT_COUNT;
                    end
                    if (r.byte_in < ring_size[slot]) begin
                        res.ok = 1'b1;
                        res.sum = SUM_W'(clip(pos + r.byte_in, 2**SUM_W - 1));
                    end
                end
            end
        endcase
        return res;
    endfunction

    // generation side keeps the sizes of the stored records, oldest first
    function automatic void queue_req(lookup_req_t r);
        if (r.op == OP_ADD) begin
            gen_sizes.push_back(r.size);
            if (gen_sizes.size() > SLOT_COUNT) begin
                void'(gen_sizes.pop_front());
            end
        end
        pending_reqs.push_back(r);
    endfunction

    function automatic void push_req(op_t op, logic [HANDLE_W-1:0] h,
                                     logic [IN_SIZE_W-1:0] sz, logic [OFFSET_W-1:0] off,
                                     logic [REC_W-1:0] rec, logic [IN_SIZE_W-1:0] b);
        lookup_req_t r;
        r.op = op;
        r.handle = h;
        r.size = sz;
        r.offset = off;
        r.rec_num = rec;
        r.byte_in = b;
        queue_req(r);
    endfunction

    function automatic lookup_req_t random_request();
        lookup_req_t r;
        int unsigned total;
        int unsigned pick;
        int unsigned rec;
        r.handle = $urandom();
        r.size = IN_SIZE_W'($urandom());
        r.offset = OFFSET_W'($urandom());
        r.rec_num = REC_W'($urandom());
        r.byte_in = IN_SIZE_W'($urandom());
        total = 0;
        foreach (gen_sizes[i]) begin
            total += gen_sizes[i];
        end
        pick = $urandom_range(99);
        if (pick < 35) begin
            r.op = OP_ADD;
            pick = $urandom_range(9);
            if (pick < 5) begin
                r.size = IN_SIZE_W'($urandom_range(64));
            end else if (pick < 8) begin
                r.size = IN_SIZE_W'($urandom_range(4095));
            end
        end else if (pick < 65) begin
            r.op = OP_FIND;
            if ($urandom_range(9) < 7) begin
                r.offset = OFFSET_W'($urandom_range(total + total / 8 + 1));
            end
        end else if (pick < 75) begin
            r.op = OP_TOTAL;
        end else begin
            r.op = OP_POSITION;
            if ($urandom_range(4) < 4) begin
                rec = $urandom_range(gen_sizes.size());
                if (rec > 2**REC_W - 1) begin
                    rec = 2**REC_W - 1;
                end
                r.rec_num = REC_W'(rec);
                if (rec < gen_sizes.size() && $urandom_range(9) < 7) begin
                    r.byte_in = IN_SIZE_W'($urandom_range(gen_sizes[rec]));
                end
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, logic [HANDLE_W-1:0] exp_v,
                                        logic [HANDLE_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    task automatic wait_all_returned();
        do begin
            @(posedge aclk);
        end while (pending_reqs.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_accepted) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_req = pending_reqs.pop_front();
                s_valid <= 1'b1;
                s_operation <= cur_req.op;
                s_record_handle <= cur_req.handle;
                s_record_size <= cur_req.size;
                s_byte_offset <= cur_req.offset;
                s_record_number <= cur_req.rec_num;
                s_byte_in_record <= cur_req.byte_in;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side ready, with an optional long hold-off
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        s_accepted = 1'b0;
        if (aresetn) begin
            s_accepted = s_valid && s_ready;
            if (s_accepted) begin
                seen_req.op = op_t'(s_operation);
                seen_req.handle = s_record_handle;
                seen_req.size = s_record_size;
                seen_req.offset = s_byte_offset;
                seen_req.rec_num = s_record_number;
                seen_req.byte_in = s_byte_in_record;
                expected_results.push_back(apply_request(seen_req));
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("ok", HANDLE_W'(want.ok), HANDLE_W'(m_ok));
                    check_field("found_handle", want.handle, m_found_handle);
                    check_field("found_size", HANDLE_W'(want.size),
                                HANDLE_W'(m_found_size));
                    check_field("offset_in_found", HANDLE_W'(want.offs),
                                HANDLE_W'(m_offset_in_found));
                    check_field("sum_bytes", HANDLE_W'(want.sum), HANDLE_W'(m_sum_bytes));
                end
            end
            if (s_accepted || (m_valid && m_ready) || (pending_reqs.size() == 0 && !s_valid
                    && expected_results.size() == 0)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        fork
            begin
                // empty ring
                push_req(OP_FIND, '0, '0, '0, '0, '0);
                push_req(OP_TOTAL, '0, '0, '0, '0, '0);
                push_req(OP_POSITION, '0, '0, '0, '0, '0);
                // zero-size, largest and one-byte records
                push_req(OP_ADD, '0, '0, '0, '0, '0);
                push_req(OP_ADD, '1, '1, '0, '0, '0);
                push_req(OP_ADD, 32'h1234_5678, 16'd1, '0, '0, '0);
                // zero-size record skipped, boundary hit and miss
                push_req(OP_FIND, '0, '0, 20'd0, '0, '0);
                push_req(OP_FIND, '0, '0, 20'd65535, '0, '0);
                push_req(OP_FIND, '0, '0, 20'd65536, '0, '0);
                push_req(OP_TOTAL, '0, '0, '0, '0, '0);
                push_req(OP_POSITION, '0, '0, '0, 4'd0, 16'd0);
                push_req(OP_POSITION, '0, '0, '0, 4'd1, 16'hFFFE);
                push_req(OP_POSITION, '0, '0, '0, 4'd3, 16'd0);
                repeat (13) begin
                    push_req(OP_ADD, $urandom(), '1, '0, '0, '0);
                end
                push_req(OP_TOTAL, '0, '0, '0, '0, '0);
                push_req(OP_FIND, '0, '0, '1, '0, '0);
                push_req(OP_POSITION, '0, '0, '0, '1, '1);
                push_req(OP_POSITION, '0, '0, '0, '1, 16'hFFFE);
                wait_all_returned();

                for (int phase = 0; phase < 4; phase++) begin
                    case (phase)
                        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
                    endcase
                    if (phase == 0) begin
                        hold_request = 1'b1;
                    end
                    repeat (PHASE_ITEMS) begin
                        queue_req(random_request());
                    end
                    wait_all_returned();
                end
                repeat (TAIL_CYCLES) @(posedge aclk);
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                timed_out = 1'b1;
            end
        join_any
        if (!timed_out && n_errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
